### rtl/lsi_pkg.sv
// Shared types and constants for the linear spline interpolator.
package lsi_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam logic [6:0]  POINT_COUNT_RST = 7'd2;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_VALUE = 2'd1;
    localparam logic [1:0] MODE_SLOPE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam int unsigned MUL_STEPS = 33;
    localparam int unsigned DIV_STEPS = 66;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } lsi_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               in_range;
        logic [5:0]         segment_index;
        logic               saturated;
    } lsi_out_t;

    typedef struct packed {
        logic start;
        logic use_mul;
    } md_ctl_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_X0,
        S_XL,
        S_RANGE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_WAIT,
        S_FIN,
        S_OUT
    } lsi_state_t;

endpackage

### rtl/linear_spline_interpolator.sv
// Top level: breakpoint tables, segment search sequencer and result formatting.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | in_item   (lsi_in_t)
//  out     | out | out_valid/out_stall| out_item  (lsi_out_t)
//  cfg     | in  | cfg_we             | cfg_wdata (point_count)
//
// A load is written into the tables when it is accepted. A value or slope query runs a linear
// scan of the x table (S_SCAN_RD, then S_SCAN_CMP per entry), then 33 multiply (value only)
// and 66 divide steps in lsi_muldiv. A query at the last breakpoint skips the scan; a
// zero-width segment skips the multiply and divide. Out of range queries go from the range
// check straight to the output. One item at a time; for a query in_stall is high
// from accept until the result leaves. out_stall holds the result in place.
// Reset sets point_count to 2; table contents are undefined until loaded.
module linear_spline_interpolator
    import lsi_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  lsi_in_t    in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output lsi_out_t   out_item,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata
);

    localparam int unsigned AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned EW = CW + 7;

    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];

    lsi_state_t         state_reg, state_next;
    logic [6:0]         point_count_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] qx_reg;
    logic signed [31:0] x0_reg;
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic signed [31:0] rdx_reg;
    logic signed [31:0] rdy_reg;
    logic [AW-1:0]      seg_reg;
    logic [AW-1:0]      k_reg;
    logic               neg_reg;
    logic [65:0]        q_reg;
    lsi_out_t           out_reg;

    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      pc_ext;
    logic [CW-1:0]      n_eff;
    logic [AW-1:0]      last_pt;
    logic [AW-1:0]      last_seg;
    logic               accept;
    logic               load_ok;
    logic               out_of_range;
    logic               is_value;

    logic signed [32:0] dx, dy, dt;
    logic [32:0]        mag_dx, mag_dy, mag_dt;
    logic               dx_zero;
    md_ctl_t            md_ctl;
    logic [65:0]        md_opnd;
    logic               md_done;
    logic [65:0]        md_quo;

    logic signed [67:0] base;
    logic signed [67:0] vsum;
    logic               sat_lo, sat_hi;

    assign pc_ext = EW'(point_count_reg);
    always_comb
    begin
        if (pc_ext < EW'(2))
            n_eff = CW'(2);
        else if (pc_ext > EW'(MAX_POINTS))
            n_eff = CW'(MAX_POINTS);
        else
            n_eff = CW'(pc_ext);
    end
    assign last_pt  = AW'(n_eff - CW'(1));
    assign last_seg = AW'(n_eff - CW'(2));

    assign accept  = in_valid && !in_stall;
    assign load_ok = (EW'(in_item.point_index) < EW'(MAX_POINTS));
    assign is_value = (mode_reg == MODE_VALUE);
    assign out_of_range = (qx_reg < x0_reg) || (qx_reg > rdx_reg);

    // segment arithmetic, exact in 33 bits
    assign dx     = {rdx_reg[31], rdx_reg} - {x1_reg[31], x1_reg};
    assign dy     = {rdy_reg[31], rdy_reg} - {y1_reg[31], y1_reg};
    assign dt     = {qx_reg[31], qx_reg} - {x1_reg[31], x1_reg};
    assign mag_dx = dx[32] ? 33'(-dx) : 33'(dx);
    assign mag_dy = dy[32] ? 33'(-dy) : 33'(dy);
    assign mag_dt = dt[32] ? 33'(-dt) : 33'(dt);
    assign dx_zero = (dx == 33'sd0);
    assign md_opnd = is_value ? {33'd0, mag_dt} : {17'd0, mag_dy, 16'd0};

    assign base   = is_value ? 68'(y1_reg) : 68'sd0;
    assign vsum   = neg_reg ? (base - $signed({2'b00, q_reg}))
                            : (base + $signed({2'b00, q_reg}));
    assign sat_lo = vsum[67] && !(&vsum[66:31]);
    assign sat_hi = !vsum[67] && (|vsum[66:31]);

    lsi_muldiv u_muldiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (md_ctl),
        .mcand    (mag_dy),
        .divisor  (mag_dx),
        .opnd     (md_opnd),
        .done     (md_done),
        .quotient (md_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_item.mode == MODE_VALUE || in_item.mode == MODE_SLOPE))
                    state_next = S_X0;
            end
            S_X0:   state_next = S_XL;
            S_XL:   state_next = S_RANGE;
            S_RANGE:
            begin
                if (out_of_range)
                    state_next = S_OUT;
                else if (qx_reg == rdx_reg)
                    state_next = S_RD_A;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD: state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (k_reg == last_seg)
                    state_next = S_RD_A;
                else
                    state_next = S_SCAN_RD;
            end
            S_RD_A: state_next = S_RD_B;
            S_RD_B: state_next = S_CALC;
            S_CALC: state_next = dx_zero ? S_FIN : S_WAIT;
            S_WAIT:
            begin
                if (md_done)
                    state_next = S_FIN;
            end
            S_FIN: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and read address
    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        out_valid      = (state_reg == S_OUT);
        md_ctl.start   = (state_reg == S_CALC) && !dx_zero;
        md_ctl.use_mul = is_value;
        case (state_reg)
            S_X0:      rd_addr = '0;
            S_XL:      rd_addr = last_pt;
            S_SCAN_RD: rd_addr = k_reg;
            S_RD_A:    rd_addr = seg_reg;
            S_RD_B:    rd_addr = AW'(seg_reg + AW'(1));
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= POINT_COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                point_count_reg <= cfg_wdata;
        end
    end

    // tables
    always_ff @(posedge clk)
    begin
        if (accept && in_item.mode == MODE_LOAD && load_ok)
        begin
            x_mem[AW'(in_item.point_index)] <= in_item.point_x;
            y_mem[AW'(in_item.point_index)] <= in_item.point_y;
        end
        rdx_reg <= x_mem[rd_addr];
        rdy_reg <= y_mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg <= in_item.mode;
                qx_reg   <= in_item.query_x;
            end
            S_XL: x0_reg <= rdx_reg;
            S_RANGE:
            begin
                k_reg   <= '0;
                seg_reg <= (qx_reg == rdx_reg) ? last_seg : '0;
                out_reg <= '0;
            end
            S_SCAN_CMP:
            begin
                if (rdx_reg <= qx_reg)
                    seg_reg <= k_reg;
                k_reg <= AW'(k_reg + AW'(1));
            end
            S_RD_B:
            begin
                x1_reg <= rdx_reg;
                y1_reg <= rdy_reg;
            end
            S_CALC:
            begin
                neg_reg <= is_value ? (dy[32] ^ dt[32] ^ dx[32]) : (dy[32] ^ dx[32]);
                q_reg   <= '0;
            end
            S_WAIT:
            begin
                if (md_done)
                    q_reg <= md_quo;
            end
            S_FIN:
            begin
                out_reg.in_range      <= 1'b1;
                out_reg.segment_index <= 6'(seg_reg);
                out_reg.saturated     <= sat_lo || sat_hi;
                if (sat_lo)
                    out_reg.result_value <= 32'sh8000_0000;
                else if (sat_hi)
                    out_reg.result_value <= 32'sh7FFF_FFFF;
                else
                    out_reg.result_value <= vsum[31:0];
            end
            default: out_reg <= out_reg;
        endcase
    end

    assign out_item = out_reg;

endmodule

### rtl/lsi_muldiv.sv
// Serial shift-add multiplier followed by restoring divider, each with its own adder; multiply only for use_mul.
module lsi_muldiv
    import lsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md_ctl_t     ctl,
    input  logic [32:0] mcand,
    input  logic [32:0] divisor,
    input  logic [65:0] opnd,
    output logic        done,
    output logic [65:0] quotient
);

    md_phase_t   phase_reg, phase_next;
    logic [6:0]  cnt_reg;
    logic [65:0] prod_reg;
    logic [32:0] mcand_reg;
    logic [32:0] div_reg;
    logic        done_reg;

    logic [33:0] mul_sum;
    logic [33:0] trial;
    logic        mul_last;
    logic        div_last;

    assign mul_sum  = {1'b0, prod_reg[65:33]} + (prod_reg[0] ? {1'b0, mcand_reg} : 34'd0);
    assign mul_last = (cnt_reg == 7'(MUL_STEPS - 1));
    assign div_last = (cnt_reg == 7'(DIV_STEPS - 1));

    // remainder lives in mcand_reg during the divide phase
    assign trial = {mcand_reg, prod_reg[65]} - {1'b0, div_reg};

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MD_IDLE:
            begin
                if (ctl.start)
                    phase_next = ctl.use_mul ? MD_MUL : MD_DIV;
            end
            MD_MUL:
            begin
                if (mul_last)
                    phase_next = MD_DIV;
            end
            MD_DIV:
            begin
                if (div_last)
                    phase_next = MD_IDLE;
            end
            default: phase_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MD_DIV) && div_last;
            if (phase_reg != phase_next)
                cnt_reg <= 7'd0;
            else
                cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MD_IDLE:
            begin
                if (ctl.start)
                begin
                    prod_reg  <= opnd;
                    mcand_reg <= ctl.use_mul ? mcand : 33'd0;
                    div_reg   <= divisor;
                end
            end
            MD_MUL:
            begin
                prod_reg <= {mul_sum, prod_reg[32:1]};
                if (mul_last)
                    mcand_reg <= 33'd0;
            end
            MD_DIV:
            begin
                if (!trial[33])
                begin
                    mcand_reg <= trial[32:0];
                    prod_reg  <= {prod_reg[64:0], 1'b1};
                end
                else
                begin
                    mcand_reg <= {mcand_reg[31:0], prod_reg[65]};
                    prod_reg  <= {prod_reg[64:0], 1'b0};
                end
            end
            default: prod_reg <= prod_reg;
        endcase
    end

    assign done     = done_reg;
    assign quotient = prod_reg;

endmodule

### tb/lsi_checker.sv
// Checker for the linear spline interpolator: predicts each query result and compares.
module lsi_checker
    import lsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  lsi_in_t    in_item,
    input  logic       out_valid,
    input  logic       out_stall,
    input  lsi_out_t   out_item,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    output int         fails,
    output int         pending
);

    logic signed [31:0] bx [MAX_POINTS_DEF];
    logic signed [31:0] by [MAX_POINTS_DEF];
    logic [6:0]         count_q;
    lsi_out_t           result_q [$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // returns {saturated, value}
    function automatic logic [32:0] clip(input bit neg, input longint unsigned m);
        if (neg)
        begin
            if (m > 64'd2147483648) return {1'b1, 32'h8000_0000};
            return {1'b0, 32'(64'd0 - m)};
        end
        if (m > 64'd2147483647) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, 32'(m)};
    endfunction

    function automatic bit interpolate(input lsi_in_t it, output lsi_out_t r);
        int n;
        int seg;
        longint x, x1, xl, dx, dy, t, v;
        longint unsigned q;
        bit neg;
        logic [32:0] c;
        r = '0;
        if (it.mode == MODE_LOAD)
        begin
            bx[it.point_index] = it.point_x;
            by[it.point_index] = it.point_y;
            return 0;
        end
        if (it.mode != MODE_VALUE && it.mode != MODE_SLOPE) return 0;
        n = count_q;
        if (n < 2) n = 2;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        x  = it.query_x;
        xl = bx[n-1];
        if (x < longint'(bx[0]) || x > xl) return 1;
        seg = 0;
        if (x == xl) seg = n - 2;
        else
            for (int k = 0; k + 1 < n; k++)
                if (longint'(bx[k]) <= x) seg = k;
        x1 = bx[seg];
        dx = longint'(bx[seg+1]) - x1;
        dy = longint'(by[seg+1]) - longint'(by[seg]);
        c  = '0;
        if (it.mode == MODE_VALUE)
        begin
            if (dx == 0) c = {1'b0, by[seg]};
            else
            begin
                t   = x - x1;
                neg = ((dy < 0) != (t < 0)) != (dx < 0);
                q   = (magnitude(dy) * magnitude(t)) / magnitude(dx);
                if (dy == 0 || t == 0) neg = 0;
                if (q > 64'h100_0000_0000) c = clip(neg, q);
                else
                begin
                    v = longint'(by[seg]) + (neg ? -longint'(q) : longint'(q));
                    c = clip(v < 0, magnitude(v));
                end
            end
        end
        else if (dx != 0)
        begin
            neg = (dy < 0) != (dx < 0);
            q   = (magnitude(dy) << 16) / magnitude(dx);
            if (q == 0) neg = 0;
            c = clip(neg, q);
        end
        r.result_value  = c[31:0];
        r.in_range      = 1'b1;
        r.segment_index = 6'(seg);
        r.saturated     = c[32];
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lsi_out_t r, e;
        if (!rst_n)
        begin
            count_q = POINT_COUNT_RST;
            fails   = 0;
            result_q.delete();
            foreach (bx[k])
            begin
                bx[k] = '0;
                by[k] = '0;
            end
        end
        else
        begin
            if (cfg_we) count_q = cfg_wdata;
            if (in_valid && !in_stall)
                if (interpolate(in_item, r)) result_q.push_back(r);
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", out_item);
                end
                else
                begin
                    e = result_q.pop_front();
                    if (out_item !== e)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp val %h rng %b seg %0d sat %b, got val %h rng %b seg %0d sat %b",
                                     e.result_value, e.in_range, e.segment_index, e.saturated,
                                     out_item.result_value, out_item.in_range,
                                     out_item.segment_index, out_item.saturated);
                    end
                end
            end
        end
        pending = result_q.size();
    end

endmodule

### tb/tb.sv
// Testbench top: table loads, queries, count settings, handshake pressure and verdict.
module tb
    import lsi_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    lsi_in_t    in_item;
    logic       out_valid;
    logic       out_stall;
    lsi_out_t   out_item;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    int         fails;
    int         pending;
    int         idle_cycles;
    bit         long_hold;
    bit         no_gaps;

    logic signed [31:0] px [64];
    logic signed [31:0] py [64];
    int                 npts;

    linear_spline_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    lsi_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver
    initial
    begin
        int n;
        bit held;
        out_stall = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 3);
            if (long_hold && !held)
            begin
                n = 400;
                held = 1;
            end
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send(input lsi_in_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic load(input int idx, input logic [31:0] x, input logic [31:0] y);
        lsi_in_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.point_index = 6'(idx);
        it.point_x = x;
        it.point_y = y;
        it.query_x = $urandom;
        px[idx] = x;
        py[idx] = y;
        send(it);
    endtask

    task automatic query(input logic [1:0] m, input logic [31:0] x);
        lsi_in_t it;
        it.mode = m;
        it.point_index = $urandom;
        it.point_x = $urandom;
        it.point_y = $urandom;
        it.query_x = x;
        send(it);
    endtask

    // wait for drain plus the longest query latency, then write the count
    task automatic set_count(input logic [6:0] v);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        npts = (v < 2) ? 2 : (v > 64 ? 64 : v);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // kinds: 0 sorted, 1 sorted with zero-width segments, 2 unsorted, 3 steep, 4 full span
    task automatic build_table(input int kind);
        longint xv, step;
        xv = -longint'($urandom_range(0, 32'h4000_0000));
        if (kind == 4) step = 64'h1_0000_0000 / npts;
        for (int k = 0; k < 64; k++)
        begin
            case (kind)
                2: load(k, $urandom, $urandom);
                3: load(k, 32'(xv + k * $urandom_range(1, 16)), $urandom);
                4: load(k, (k == npts - 1) ? 32'h7FFF_FFFF : 32'(-64'sd2147483648 + k * step),
                         $urandom);
                default:
                begin
                    load(k, 32'(xv), ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'hFFFFF));
                    if (!(kind == 1 && $urandom_range(0, 3) == 0))
                        xv += $urandom_range(1, 32'h100_0000);
                end
            endcase
        end
    endtask

    function automatic logic [31:0] pick_x();
        int k;
        k = $urandom_range(0, npts - 1);
        case ($urandom_range(0, 7))
            0: return px[k];
            1: return px[npts-1];
            2: return px[0] - 32'($urandom_range(1, 4));
            3: return px[npts-1] + 32'($urandom_range(1, 4));
            4: return $urandom;
            5: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'(longint'(px[k]) +
                        (k + 1 < npts ? (longint'(px[k+1]) - longint'(px[k])) *
                         $urandom_range(0, 1000) / 1000 : 0));
        endcase
    endfunction

    initial
    begin
        logic [6:0] counts [12];
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        long_hold = 0;
        no_gaps = 0;
        npts = 2;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: 3-point table with a zero-width segment, edges and extremes
        set_count(7'd3);
        for (int k = 3; k < 64; k++) load(k, $urandom, $urandom);
        load(0, 32'h8000_0000, 32'h7FFF_FFFF);
        load(1, 32'h0001_0000, 32'h8000_0000);
        load(2, 32'h0001_0000, 32'h0002_0000);
        query(MODE_VALUE, 32'h8000_0000);
        query(MODE_SLOPE, 32'h8000_0000);
        query(MODE_VALUE, 32'h0000_8000);
        query(MODE_SLOPE, 32'h0000_8000);
        query(MODE_VALUE, 32'h0001_0000);
        query(MODE_SLOPE, 32'h0001_0000);
        query(MODE_VALUE, 32'h0001_0001);
        query(MODE_VALUE, 32'h7FFF_FFFF);
        query(MODE_NONE, 32'h0);
        load(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(MODE_SLOPE, 32'h7FFF_FFFF);
        query(MODE_VALUE, 32'h4000_0000);
        // table x 0, 0x10, 0x7FFF_FFFF: value and slope queries inside the last segment
        load(1, 32'h0000_0010, 32'h7FFF_FFFF);
        load(0, 32'h0000_0000, 32'h0000_0000);
        query(MODE_VALUE, 32'h7000_0000);
        query(MODE_SLOPE, 32'h7000_0000);

        counts = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd2, 7'd64, 7'd5,
                   7'd16, 7'd40, 7'd3, 7'd64, 7'd9};
        for (int p = 0; p < 12; p++)
        begin
            no_gaps = (p % 4 == 3);
            set_count(counts[p] == 7'd9 ? 7'($urandom_range(2, 64)) : counts[p]);
            build_table(p % 5);
            if (p == 2) long_hold = 1;
            for (int q = 0; q < 85; q++)
            begin
                case ($urandom_range(0, 19))
                    0: query(MODE_NONE, $urandom);
                    1: load($urandom_range(npts, 63) % 64, $urandom, $urandom);
                    2: load($urandom_range(0, 63), $urandom, $urandom);
                    default: query($urandom_range(0, 1) ? MODE_VALUE : MODE_SLOPE, pick_x());
                endcase
            end
        end

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### linear_spline_interpolator.f
rtl/lsi_pkg.sv
rtl/lsi_muldiv.sv
rtl/linear_spline_interpolator.sv
tb/lsi_checker.sv
tb/tb.sv
